>>> rtl/nf4dq_pkg.sv
`default_nettype none
package nf4dq_pkg;

	localparam int BLK_W  = 13;
	localparam int CFG_W  = 13;
	localparam int CODE_W = 16;
	localparam int SCL_W  = 16;
	localparam int ACT_W  = 16;
	localparam int CS_W   = 32;
	localparam int PROD_W = 48;
	localparam int SUM_W  = 49;
	localparam int ACC_W  = 60;

	localparam logic [3:0] REG_ROW_LENGTH   = 4'd0;
	localparam logic [3:0] REG_BLOCK_LENGTH = 4'd1;

	typedef struct packed {
		logic valid;
		logic last;
	} tag_t;

	typedef struct packed {
		logic             done;
		logic [BLK_W-1:0] rem;
	} rem_res_t;

	// NF4 codebook, signed Q1.15, +1.0 saturated
	function automatic logic signed [CODE_W-1:0] nf4_code(input logic [3:0] c);
		logic signed [CODE_W-1:0] v;
		unique case (c)
			4'h0: v = 16'sh8000;
			4'h1: v = -16'sd22813;
			4'h2: v = -16'sd17206;
			4'h3: v = -16'sd12941;
			4'h4: v = -16'sd9321;
			4'h5: v = -16'sd6055;
			4'h6: v = -16'sd2984;
			4'h7: v = 16'sd0;
			4'h8: v = 16'sd2608;
			4'h9: v = 16'sd5273;
			4'hA: v = 16'sd8065;
			4'hB: v = 16'sd11073;
			4'hC: v = 16'sd14441;
			4'hD: v = 16'sd18436;
			4'hE: v = 16'sd23690;
			4'hF: v = 16'sd32767;
			default: v = 16'sd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

>>> rtl/nf4dq_rem.sv
`default_nettype none
// restoring remainder, one dividend bit per cycle, MSB first
module nf4dq_rem #(
	parameter int CNT_W = 13
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [CNT_W-1:0]            dividend,
	input  wire logic [nf4dq_pkg::BLK_W-1:0] divisor,
	output logic                             busy,
	output nf4dq_pkg::rem_res_t              res
);

	localparam int BW     = nf4dq_pkg::BLK_W;
	localparam int STEP_W = (CNT_W > 1) ? $clog2(CNT_W) : 1;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [BW-1:0]     r_q;
	logic [BW:0]       shifted;
	logic [BW-1:0]     r_nx;

	always_comb begin
		shifted = {r_q, dividend[step_q]};
		if (shifted >= {1'b0, divisor}) begin
			r_nx = BW'(shifted - {1'b0, divisor});
		end else begin
			r_nx = BW'(shifted);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(CNT_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= r_nx;
		end
	end

	assign busy     = busy_q | done_q;
	assign res.done = done_q;
	assign res.rem  = r_q;

endmodule
`default_nettype wire

>>> rtl/nf4dq_lane.sv
`default_nettype none
// one element: codebook lookup, code*scale, then *activation
module nf4dq_lane (
	input  wire logic                                     clk,
	input  wire logic                                     adv,
	input  wire logic [3:0]                               nibble,
	input  wire logic [nf4dq_pkg::SCL_W-1:0]              scale,
	input  wire logic signed [nf4dq_pkg::ACT_W-1:0]       act,
	output logic signed [nf4dq_pkg::PROD_W-1:0]           prod
);

	localparam int CS_W   = nf4dq_pkg::CS_W;
	localparam int PROD_W = nf4dq_pkg::PROD_W;

	logic signed [nf4dq_pkg::CODE_W-1:0] code;
	logic signed [nf4dq_pkg::SCL_W:0]    scale_sx;
	logic signed [CS_W-1:0]              cs_s1;
	logic signed [nf4dq_pkg::ACT_W-1:0]  act_s1;
	logic signed [PROD_W-1:0]            prod_s2;

	assign code     = nf4dq_pkg::nf4_code(nibble);
	assign scale_sx = signed'({1'b0, scale});

	always_ff @(posedge clk) begin
		if (adv) begin
			cs_s1   <= CS_W'(CS_W'(code) * CS_W'(scale_sx));
			act_s1  <= act;
			prod_s2 <= PROD_W'(PROD_W'(cs_s1) * PROD_W'(act_s1));
		end
	end

	assign prod = prod_s2;

endmodule
`default_nettype wire

>>> rtl/nf4dq_merge.sv
`default_nettype none
// adds the lane products, accumulates, holds the finished row sum
module nf4dq_merge (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire nf4dq_pkg::tag_t                        tag_s2,
	input  wire logic signed [nf4dq_pkg::PROD_W-1:0]    prod_e,
	input  wire logic signed [nf4dq_pkg::PROD_W-1:0]    prod_o,
	input  wire logic                                   dot_stall,
	output logic                                        adv,
	output logic                                        dot_valid,
	output logic signed [nf4dq_pkg::ACC_W-1:0]          dot_sum
);

	localparam int SUM_W = nf4dq_pkg::SUM_W;
	localparam int ACC_W = nf4dq_pkg::ACC_W;

	nf4dq_pkg::tag_t          tag_s3;
	logic signed [SUM_W-1:0]  sum_s3;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  acc_nx;
	logic                     dot_valid_q;
	logic signed [ACC_W-1:0]  dot_sum_q;

	assign adv    = !(dot_valid_q && dot_stall);
	assign acc_nx = acc_q + ACC_W'(sum_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3      <= '0;
			acc_q       <= '0;
			dot_valid_q <= 1'b0;
		end else if (adv) begin
			tag_s3      <= tag_s2;
			dot_valid_q <= tag_s3.valid && tag_s3.last;
			if (tag_s3.valid) begin
				acc_q <= tag_s3.last ? '0 : acc_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3 <= SUM_W'(prod_e) + SUM_W'(prod_o);
			if (tag_s3.valid && tag_s3.last) begin
				dot_sum_q <= acc_nx;
			end
		end
	end

	assign dot_valid = dot_valid_q;
	assign dot_sum   = dot_sum_q;

endmodule
`default_nettype wire

>>> rtl/nf4_dequant_dot_product.sv
`default_nettype none
// channel   direction  signals
// item      in         item_valid / item_stall : weight_byte act_even act_odd block_scale
// dot       out        dot_valid / dot_stall   : dot_sum
// cfg       in         cfg_valid / cfg_ready   : cfg_index cfg_data
//
// One word per cycle unless item_stall; a last word passes s1, s2, s3 and sets dot_valid.
// Two lanes (even, odd nibble) run a two-stage multiply, then one add stage and the accumulator.
// A cfg write starts a remainder pass that realigns the block position; item_stall and
// !cfg_ready are held until its result is loaded. A held dot word stalls the whole pipe.
// Reset clears the control state and the accumulator and sets both lengths to 64.
module nf4_dequant_dot_product #(
	parameter int MAX_ROW = 4096
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                item_valid,
	output logic                                     item_stall,
	input  wire logic [7:0]                          weight_byte,
	input  wire logic signed [nf4dq_pkg::ACT_W-1:0]  act_even,
	input  wire logic signed [nf4dq_pkg::ACT_W-1:0]  act_odd,
	input  wire logic [nf4dq_pkg::SCL_W-1:0]         block_scale,
	output logic                                     dot_valid,
	input  wire logic                                dot_stall,
	output logic signed [nf4dq_pkg::ACC_W-1:0]       dot_sum,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [3:0]                          cfg_index,
	input  wire logic [nf4dq_pkg::CFG_W-1:0]         cfg_data
);

	localparam int BW        = nf4dq_pkg::BLK_W;
	localparam int CW        = nf4dq_pkg::CFG_W;
	localparam int ROW_CAP_I = (MAX_ROW >= 8190) ? 8190 : ((MAX_ROW / 2) * 2);
	localparam int CNT_W     = $clog2(ROW_CAP_I + 1);
	localparam logic [CW-1:0] ROW_CAP  = CW'(ROW_CAP_I);
	localparam logic [CW-1:0] LEN_MIN  = CW'(2);
	localparam logic [CW-1:0] LEN_RST  = CW'(64);

	logic [CW-1:0]              row_len_q;
	logic [CW-1:0]              blk_len_q;
	logic [CNT_W-1:0]           count_q;
	logic [BW-1:0]              pos_q;
	logic [nf4dq_pkg::SCL_W-1:0] held_q;

	logic [CW-1:0]              rlen;
	logic [CW-1:0]              blen;
	logic [CW-1:0]              row_even;
	logic [CW-1:0]              blk_even;
	logic [CNT_W:0]             count_nx;
	logic [BW:0]                pos_nx;
	logic                       last;
	logic [nf4dq_pkg::SCL_W-1:0] scale_use;

	logic                       adv;
	logic                       accept;
	logic                       cfg_we;
	logic                       rem_busy;
	nf4dq_pkg::rem_res_t        rem_res;
	nf4dq_pkg::tag_t            tag_s1;
	nf4dq_pkg::tag_t            tag_s2;
	logic signed [nf4dq_pkg::PROD_W-1:0] prod_e;
	logic signed [nf4dq_pkg::PROD_W-1:0] prod_o;

	assign item_stall = !adv || rem_busy;
	assign cfg_ready  = !rem_busy;
	assign accept     = item_valid && !item_stall;
	assign cfg_we     = cfg_valid && cfg_ready;

	always_comb begin
		row_even = {row_len_q[CW-1:1], 1'b0};
		blk_even = {blk_len_q[CW-1:1], 1'b0};
		priority if (row_even < LEN_MIN) begin
			rlen = LEN_MIN;
		end else if (row_even > ROW_CAP) begin
			rlen = ROW_CAP;
		end else begin
			rlen = row_even;
		end
		blen      = (blk_even < LEN_MIN) ? LEN_MIN : blk_even;
		count_nx  = {1'b0, count_q} + (CNT_W+1)'(2);
		last      = (CW+1)'(count_nx) >= {1'b0, rlen};
		pos_nx    = {1'b0, pos_q} + (BW+1)'(2);
		scale_use = (pos_q == '0) ? block_scale : held_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_len_q <= LEN_RST;
			blk_len_q <= LEN_RST;
			count_q   <= '0;
			pos_q     <= '0;
			held_q    <= '0;
			tag_s1    <= '0;
			tag_s2    <= '0;
		end else begin
			if (cfg_we && cfg_index == nf4dq_pkg::REG_ROW_LENGTH) begin
				row_len_q <= cfg_data;
			end
			if (cfg_we && cfg_index == nf4dq_pkg::REG_BLOCK_LENGTH) begin
				blk_len_q <= cfg_data;
			end
			if (rem_res.done) begin
				pos_q <= rem_res.rem;
			end else if (accept) begin
				held_q <= scale_use;
				if (last) begin
					count_q <= '0;
					pos_q   <= '0;
				end else begin
					count_q <= CNT_W'(count_nx);
					pos_q   <= (pos_nx >= (BW+1)'(blen)) ? '0 : BW'(pos_nx);
				end
			end
			if (adv) begin
				tag_s1 <= '{valid: accept, last: last};
				tag_s2 <= tag_s1;
			end
		end
	end

	nf4dq_rem #(
		.CNT_W (CNT_W)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cfg_we),
		.dividend (count_q),
		.divisor  (BW'(blen)),
		.busy     (rem_busy),
		.res      (rem_res)
	);

	nf4dq_lane u_lane_e (
		.clk    (clk),
		.adv    (adv),
		.nibble (weight_byte[7:4]),
		.scale  (scale_use),
		.act    (act_even),
		.prod   (prod_e)
	);

	nf4dq_lane u_lane_o (
		.clk    (clk),
		.adv    (adv),
		.nibble (weight_byte[3:0]),
		.scale  (scale_use),
		.act    (act_odd),
		.prod   (prod_o)
	);

	nf4dq_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_s2    (tag_s2),
		.prod_e    (prod_e),
		.prod_o    (prod_o),
		.dot_stall (dot_stall),
		.adv       (adv),
		.dot_valid (dot_valid),
		.dot_sum   (dot_sum)
	);

endmodule
`default_nettype wire
